// File: hdl/lspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspq_pkg
// shared types and codes of the linear-scan priority queue
// ----------------------------------------------------------------------------
package lspq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]  prio;
        logic [16:0] ident;
        logic [15:0] seq;
        logic [7:0]  src;
        logic [2:0]  run;
    } job_rec_t;

    localparam int REC_W = $bits(job_rec_t);

endpackage
`default_nettype wire

// File: hdl/lspq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspq_req_if
// request channel: insert or remove command with the job record
// ----------------------------------------------------------------------------
interface lspq_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  job_priority;
    logic [16:0] job_ident;
    logic [15:0] job_sequence;
    logic [7:0]  job_source;
    logic [2:0]  job_runtime;

    modport source (
        output valid, command, job_priority, job_ident, job_sequence, job_source,
               job_runtime,
        input  ready
    );

    modport sink (
        input  valid, command, job_priority, job_ident, job_sequence, job_source,
               job_runtime,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/lspq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspq_rsp_if
// response channel: status, removed job and queue occupancy
// ----------------------------------------------------------------------------
interface lspq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  out_priority;
    logic [16:0] out_ident;
    logic [15:0] out_sequence;
    logic [7:0]  out_source;
    logic [2:0]  out_runtime;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic        is_full;

    modport source (
        output valid, status, out_priority, out_ident, out_sequence, out_source,
               out_runtime, occupancy, is_empty, is_full,
        input  ready
    );

    modport sink (
        input  valid, status, out_priority, out_ident, out_sequence, out_source,
               out_runtime, occupancy, is_empty, is_full,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/linear_scan_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_unit
// fixed-capacity job queue, insert at tail, remove highest priority (oldest
// among equals) and close the gap
// ----------------------------------------------------------------------------
// The job records live in one ram with a single read port and a registered
// read. An insert, and any refused request, goes from acceptance to ST_EMIT,
// which loads the response into the output register once that is free. A
// remove from a queue holding n jobs reads every entry once to find the
// winner at slot k, then moves the n-1-k later entries down one slot, one
// entry per cycle through the read port. A new request is taken as soon as
// the previous one has reached the output register, even if that response
// has not yet been collected.
module linear_scan_priority_queue_unit #(
    parameter int DEPTH = lspq_pkg::DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lspq_req_if.sink  req,
    lspq_rsp_if.source rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    lspq_pkg::job_rec_t  best_rec_reg, best_rec_next;
    logic [1:0]          status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    lspq_pkg::job_rec_t  out_rec_reg, out_rec_next;
    logic [4:0]          out_occ_reg, out_occ_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_full_reg, out_full_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    lspq_pkg::job_rec_t  ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [lspq_pkg::REC_W-1:0] ram_rdata;
    lspq_pkg::job_rec_t  rec_in;

    logic                req_fire;
    logic [IW-1:0]       sel_idx;
    logic [CW-1:0]       nxt_idx;
    logic [CW-1:0]       shift_idx;

    lspq_ram #(
        .WIDTH (lspq_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rec_in    = lspq_pkg::job_rec_t'(ram_rdata);
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // running best of the scan, including the entry arriving this cycle
    assign sel_idx   = ((rd_idx_reg == '0) || (rec_in.prio > best_rec_reg.prio)) ?
                       rd_idx_reg : best_idx_reg;
    assign nxt_idx   = CW'(rd_idx_reg) + CW'(1);
    assign shift_idx = CW'(sel_idx) + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        best_idx_next   = best_idx_reg;
        best_rec_next   = best_rec_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_occ_next    = out_occ_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg - IW'(1);
        ram_wdata       = rec_in;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    best_rec_next = '0;
                    if (req.command == lspq_pkg::CMD_INSERT)
                    begin
                        state_next = ST_EMIT;
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = lspq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            status_next    = lspq_pkg::STATUS_DONE;
                            ram_we         = 1'b1;
                            ram_waddr      = count_reg[IW-1:0];
                            ram_wdata.prio  = req.job_priority;
                            ram_wdata.ident = req.job_ident;
                            ram_wdata.seq   = req.job_sequence;
                            ram_wdata.src   = req.job_source;
                            ram_wdata.run   = req.job_runtime;
                            count_next     = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = lspq_pkg::STATUS_EMPTY;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        ram_raddr   = '0;
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                best_idx_next = sel_idx;
                if (sel_idx == rd_idx_reg)
                begin
                    best_rec_next = rec_in;
                end
                if (nxt_idx < count_reg)
                begin
                    ram_raddr   = nxt_idx[IW-1:0];
                    rd_idx_next = nxt_idx[IW-1:0];
                end
                else if (shift_idx < count_reg)
                begin
                    // entries above the winner move down one slot
                    ram_raddr   = shift_idx[IW-1:0];
                    rd_idx_next = shift_idx[IW-1:0];
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = lspq_pkg::STATUS_DONE;
                    state_next  = ST_EMIT;
                end
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg - IW'(1);
                ram_wdata = rec_in;
                if (nxt_idx < count_reg)
                begin
                    ram_raddr   = nxt_idx[IW-1:0];
                    rd_idx_next = nxt_idx[IW-1:0];
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = lspq_pkg::STATUS_DONE;
                    state_next  = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rec_next    = best_rec_reg;
                    out_occ_next    = 5'(count_reg);
                    out_empty_next  = (count_reg == '0);
                    out_full_next   = (count_reg == CW'(DEPTH));
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            best_idx_reg   <= '0;
            best_rec_reg   <= '0;
            status_reg     <= lspq_pkg::STATUS_DONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= lspq_pkg::STATUS_DONE;
            out_rec_reg    <= '0;
            out_occ_reg    <= '0;
            out_empty_reg  <= 1'b1;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            best_idx_reg   <= best_idx_next;
            best_rec_reg   <= best_rec_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rec_reg    <= out_rec_next;
            out_occ_reg    <= out_occ_next;
            out_empty_reg  <= out_empty_next;
            out_full_reg   <= out_full_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_priority = out_rec_reg.prio;
    assign rsp.out_ident    = out_rec_reg.ident;
    assign rsp.out_sequence = out_rec_reg.seq;
    assign rsp.out_source   = out_rec_reg.src;
    assign rsp.out_runtime  = out_rec_reg.run;
    assign rsp.occupancy    = out_occ_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.is_full      = out_full_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_SHIFT) |-> (count_reg != '0))
        else $error("scan or shift with an empty queue");

    a_shift_above_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (rd_idx_reg > best_idx_reg))
        else $error("shift moves an entry at or below the removed slot");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.command == lspq_pkg::CMD_INSERT && count_reg != CW'(DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted insert did not grow the queue");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SHIFT || (state_reg == ST_IDLE && req_fire)))
        else $error("ram written outside insert or shift");
`endif

endmodule
`default_nettype wire

// File: hdl/lspq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
